// ----- rtl/msx_pkg.sv -----
// ----------------------------------------------------------------------------
// msx_pkg
// Shared types and constants for the subset instruction execute unit.
// ----------------------------------------------------------------------------
package msx_pkg;

    localparam int NUM_REGS  = 32;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int XLEN      = 32;

    localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(NUM_REGS - 1);

    localparam logic [5:0] OP_SPECIAL = 6'b000000;
    localparam logic [5:0] OP_ADDI    = 6'b001000;
    localparam logic [5:0] OP_ANDI    = 6'b001100;
    localparam logic [5:0] OP_ORI     = 6'b001101;
    localparam logic [5:0] OP_XORI    = 6'b001110;
    localparam logic [5:0] OP_BEQ     = 6'b000100;
    localparam logic [5:0] OP_JAL     = 6'b000011;
    localparam logic [5:0] FN_JR      = 6'b001000;

    localparam logic [XLEN-1:0] JAL_KEEP_MASK = 32'hF000_0000;

    // input tdata layout
    localparam int IN_W    = 2 + XLEN + REG_IDX_W + XLEN;
    localparam int IN_TD_W = ((IN_W + 7) / 8) * 8;
    // output tdata layout
    localparam int OUT_W    = XLEN + 1 + REG_IDX_W + XLEN + 1;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_EXEC     = 2'd0,
        CMD_LOAD_REG = 2'd1,
        CMD_LOAD_PC  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [XLEN-1:0]      next_pc;
        logic                 reg_written;
        logic [REG_IDX_W-1:0] dest_index;
        logic [XLEN-1:0]      dest_value;
        logic                 unsupported;
    } exec_result_t;

    function automatic logic [XLEN-1:0] sext16(input logic [15:0] v);
        sext16 = {{(XLEN-16){v[15]}}, v};
    endfunction

endpackage

// ----- rtl/mips_subset_execute_unit.sv -----
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes a small instruction subset against a 32-entry register file and
// a program counter, or loads a register or the program counter.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while the input is not stalled. The
// register file read of both source registers is clocked at the accepting
// edge. The execute stage then decodes and executes, and when it moves on
// the block writes the register file and the program counter and fills the
// output register that drives m_axis. A back-to-back dependency on the
// register just written is served by a bypass of the last write, so there
// is no stall for it. The register file reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed and the block takes
// transactions right after reset. Backpressure on m_axis only stalls the
// input once both the execute stage and the output register hold a
// transaction.
module mips_subset_execute_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd[1:0], instruction[33:2], load_index[38:34], load_value[70:39]
    input  logic [msx_pkg::IN_TD_W-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // next_pc[31:0], reg_written[32], dest_index[37:33], dest_value[69:38],
    // unsupported[70]
    output logic [msx_pkg::OUT_TD_W-1:0]   m_axis_tdata
);

    localparam int XL = msx_pkg::XLEN;
    localparam int IW = msx_pkg::REG_IDX_W;

    logic                 s_accept;
    logic                 s1_fire;

    logic                 s1_valid_reg;
    msx_pkg::cmd_t        s1_cmd_reg;
    logic [XL-1:0]        s1_ins_reg;
    logic [IW-1:0]        s1_lidx_reg;
    logic [XL-1:0]        s1_lval_reg;
    logic [XL-1:0]        pc_reg;

    logic                 m_valid_reg;
    msx_pkg::exec_result_t m_res_reg;

    logic [XL-1:0]        in_ins;
    logic [XL-1:0]        rd_val;
    logic [XL-1:0]        rs_val;
    msx_pkg::exec_result_t res;

    assign s1_fire       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_ins        = s_axis_tdata[XL+1:2];

    msx_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (in_ins[25:21]),
        .rd_addr_b (in_ins[20:16]),
        .rd_data_a (rd_val),
        .rd_data_b (rs_val),
        .wr_en     (s1_fire && res.reg_written),
        .wr_addr   (res.dest_index),
        .wr_data   (res.dest_value)
    );

    msx_alu u_alu (
        .cmd         (s1_cmd_reg),
        .instruction (s1_ins_reg),
        .load_index  (s1_lidx_reg),
        .load_value  (s1_lval_reg),
        .pc          (pc_reg),
        .rd_val      (rd_val),
        .rs_val      (rs_val),
        .result      (res)
    );

    // payload of the execute stage and the output register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= msx_pkg::cmd_t'(s_axis_tdata[1:0]);
            s1_ins_reg  <= in_ins;
            s1_lidx_reg <= s_axis_tdata[XL+IW+1:XL+2];
            s1_lval_reg <= s_axis_tdata[2*XL+IW+1:XL+IW+2];
        end
        if (s1_fire) begin
            m_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= res.next_pc;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(msx_pkg::OUT_TD_W - msx_pkg::OUT_W){1'b0}},
                            m_res_reg.unsupported,
                            m_res_reg.dest_value,
                            m_res_reg.dest_index,
                            m_res_reg.reg_written,
                            m_res_reg.next_pc};

endmodule

// ----- rtl/msx_regfile.sv -----
// ----------------------------------------------------------------------------
// msx_regfile
// Register file memory: two registered read ports, one write port, per-entry
// valid bits for the all-zero reset and a one-deep bypass of the last write.
// ----------------------------------------------------------------------------
module msx_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [msx_pkg::REG_IDX_W-1:0] rd_addr_a,
    input  logic [msx_pkg::REG_IDX_W-1:0] rd_addr_b,
    output logic [msx_pkg::XLEN-1:0]      rd_data_a,
    output logic [msx_pkg::XLEN-1:0]      rd_data_b,
    input  logic                          wr_en,
    input  logic [msx_pkg::REG_IDX_W-1:0] wr_addr,
    input  logic [msx_pkg::XLEN-1:0]      wr_data
);

    logic [msx_pkg::XLEN-1:0]      mem [msx_pkg::NUM_REGS];
    logic [msx_pkg::NUM_REGS-1:0]  valid_reg;

    logic [msx_pkg::XLEN-1:0]      rdata_a_reg;
    logic [msx_pkg::XLEN-1:0]      rdata_b_reg;
    logic                          rvld_a_reg;
    logic                          rvld_b_reg;
    logic [msx_pkg::REG_IDX_W-1:0] raddr_a_reg;
    logic [msx_pkg::REG_IDX_W-1:0] raddr_b_reg;

    logic                          fwd_valid_reg;
    logic [msx_pkg::REG_IDX_W-1:0] fwd_addr_reg;
    logic [msx_pkg::XLEN-1:0]      fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_a_reg <= mem[rd_addr_a];
            rdata_b_reg <= mem[rd_addr_b];
            rvld_a_reg  <= valid_reg[rd_addr_a];
            rvld_b_reg  <= valid_reg[rd_addr_b];
            raddr_a_reg <= rd_addr_a;
            raddr_b_reg <= rd_addr_b;
        end
        if (wr_en) begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
            fwd_valid_reg      <= 1'b1;
        end
    end

    // the last write is always the newest value, so it may override a read
    // that was taken at the same edge the write landed
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == raddr_a_reg)) begin
            rd_data_a = fwd_data_reg;
        end else if (rvld_a_reg) begin
            rd_data_a = rdata_a_reg;
        end else begin
            rd_data_a = '0;
        end
        if (fwd_valid_reg && (fwd_addr_reg == raddr_b_reg)) begin
            rd_data_b = fwd_data_reg;
        end else if (rvld_b_reg) begin
            rd_data_b = rdata_b_reg;
        end else begin
            rd_data_b = '0;
        end
    end

endmodule

// ----- rtl/msx_alu.sv -----
// ----------------------------------------------------------------------------
// msx_alu
// Decode and execute of one command against the operands read from the
// register file and the current program counter.
// ----------------------------------------------------------------------------
module msx_alu (
    input  msx_pkg::cmd_t                 cmd,
    input  logic [msx_pkg::XLEN-1:0]      instruction,
    input  logic [msx_pkg::REG_IDX_W-1:0] load_index,
    input  logic [msx_pkg::XLEN-1:0]      load_value,
    input  logic [msx_pkg::XLEN-1:0]      pc,
    input  logic [msx_pkg::XLEN-1:0]      rd_val,
    input  logic [msx_pkg::XLEN-1:0]      rs_val,
    output msx_pkg::exec_result_t         result
);

    logic [5:0]                    op;
    logic [5:0]                    fn;
    logic [msx_pkg::REG_IDX_W-1:0] rd;
    logic [15:0]                   imm;
    logic [msx_pkg::XLEN-1:0]      imm_zx;

    assign op     = instruction[31:26];
    assign fn     = instruction[5:0];
    assign rd     = instruction[25:21];
    assign imm    = instruction[15:0];
    assign imm_zx = {{(msx_pkg::XLEN-16){1'b0}}, imm};

    always_comb begin
        result             = '0;
        result.next_pc     = pc;
        unique case (cmd)
            msx_pkg::CMD_EXEC: begin
                unique case (op)
                    msx_pkg::OP_ADDI: begin
                        result.reg_written = 1'b1;
                        result.dest_index  = rd;
                        result.dest_value  = rs_val + msx_pkg::sext16(imm);
                    end
                    msx_pkg::OP_ANDI: begin
                        result.reg_written = 1'b1;
                        result.dest_index  = rd;
                        result.dest_value  = rs_val & imm_zx;
                    end
                    msx_pkg::OP_ORI: begin
                        result.reg_written = 1'b1;
                        result.dest_index  = rd;
                        result.dest_value  = rs_val | imm_zx;
                    end
                    msx_pkg::OP_XORI: begin
                        result.reg_written = 1'b1;
                        result.dest_index  = rd;
                        result.dest_value  = rs_val ^ imm_zx;
                    end
                    msx_pkg::OP_BEQ: begin
                        if (rd_val == rs_val) begin
                            result.next_pc = pc + msx_pkg::sext16(imm);
                        end
                    end
                    msx_pkg::OP_JAL: begin
                        result.reg_written = 1'b1;
                        result.dest_index  = msx_pkg::LINK_REG;
                        result.dest_value  = pc;
                        result.next_pc     = (pc & msx_pkg::JAL_KEEP_MASK)
                                           + {6'b0, instruction[25:0]};
                    end
                    msx_pkg::OP_SPECIAL: begin
                        if (fn == msx_pkg::FN_JR) begin
                            result.next_pc = rd_val;
                        end else begin
                            result.unsupported = 1'b1;
                        end
                    end
                    default: begin
                        result.unsupported = 1'b1;
                    end
                endcase
            end
            msx_pkg::CMD_LOAD_REG: begin
                result.reg_written = 1'b1;
                result.dest_index  = load_index;
                result.dest_value  = load_value;
            end
            msx_pkg::CMD_LOAD_PC: begin
                result.next_pc = load_value;
            end
            default: begin
                // unused command code: no state change
            end
        endcase
    end

endmodule

// ----- rtl/msx_checker.sv -----
// ----------------------------------------------------------------------------
// msx_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module msx_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [msx_pkg::OUT_TD_W-1:0] m_axis_tdata
);

    // nothing in flight right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // the input only stalls while a result waits on the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // no register written means index and value read zero
    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[32] |->
            m_axis_tdata[37:33] == '0 && m_axis_tdata[69:38] == '0)
        else $error("destination fields set without a register write");

    a_unsup_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[70] |-> !m_axis_tdata[32])
        else $error("unsupported instruction wrote a register");

endmodule

bind mips_subset_execute_unit msx_checker u_msx_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the subset instruction execute unit: directed
// corner cases, random instruction streams under random idling on both
// sides, a long result stall and sender pauses. Results are scored in order
// against a cycle-free model of the register file and program counter.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_RESERVED = 2'd3;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [msx_pkg::IN_TD_W-1:0]    s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [msx_pkg::OUT_TD_W-1:0]   m_axis_tdata;

    // architectural state as the block should see it
    logic [msx_pkg::XLEN-1:0]       gold_regs [msx_pkg::NUM_REGS];
    logic [msx_pkg::XLEN-1:0]       gold_pc;

    msx_pkg::exec_result_t          pending_results [$];

    int src_max_gap    = 0;
    int sink_max_gap   = 0;
    int stall_request  = 0;
    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int branches_taken = 0;
    int unsupported_seen = 0;

    mips_subset_execute_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("mips_subset_execute_unit verification failed");
        $finish;
    end

    // apply one transaction to the model state and return its result
    function automatic msx_pkg::exec_result_t predict_result(input logic [1:0] cmd,
                                                             input logic [31:0] ins,
                                                             input logic [4:0] lidx,
                                                             input logic [31:0] lval);
        msx_pkg::exec_result_t r;
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs;
        logic [31:0] imm_z;
        logic [31:0] imm_s;
        r     = '0;
        op    = ins[31:26];
        rd    = ins[25:21];
        rs    = ins[20:16];
        imm_z = {16'h0000, ins[15:0]};
        imm_s = {{16{ins[15]}}, ins[15:0]};
        case (cmd)
            msx_pkg::CMD_EXEC: begin
                case (op)
                    msx_pkg::OP_ADDI, msx_pkg::OP_ANDI,
                    msx_pkg::OP_ORI, msx_pkg::OP_XORI: begin
                        r.reg_written = 1'b1;
                        r.dest_index  = rd;
                        case (op)
                            msx_pkg::OP_ADDI: r.dest_value = gold_regs[rs] + imm_s;
                            msx_pkg::OP_ANDI: r.dest_value = gold_regs[rs] & imm_z;
                            msx_pkg::OP_ORI:  r.dest_value = gold_regs[rs] | imm_z;
                            default:          r.dest_value = gold_regs[rs] ^ imm_z;
                        endcase
                    end
                    msx_pkg::OP_BEQ: begin
                        if (gold_regs[rd] == gold_regs[rs]) begin
                            gold_pc = gold_pc + imm_s;
                            branches_taken++;
                        end
                    end
                    msx_pkg::OP_JAL: begin
                        r.reg_written = 1'b1;
                        r.dest_index  = msx_pkg::LINK_REG;
                        r.dest_value  = gold_pc;
                        gold_pc = (gold_pc & msx_pkg::JAL_KEEP_MASK) + {6'b0, ins[25:0]};
                    end
                    msx_pkg::OP_SPECIAL: begin
                        if (ins[5:0] == msx_pkg::FN_JR)
                            gold_pc = gold_regs[rd];
                        else
                            r.unsupported = 1'b1;
                    end
                    default: r.unsupported = 1'b1;
                endcase
            end
            msx_pkg::CMD_LOAD_REG: begin
                r.reg_written = 1'b1;
                r.dest_index  = lidx;
                r.dest_value  = lval;
            end
            msx_pkg::CMD_LOAD_PC: gold_pc = lval;
            default: ;
        endcase
        if (r.reg_written)
            gold_regs[r.dest_index] = r.dest_value;
        if (r.unsupported)
            unsupported_seen++;
        r.next_pc = gold_pc;
        return r;
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rd,
                                           input logic [4:0] rs, input logic [15:0] imm);
        return {op, rd, rs, imm};
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        int pick;
        w    = $urandom();
        pick = $urandom_range(0, 99);
        // crowd onto a few registers so results feed each other
        if (pick < 66 && $urandom_range(0, 1) == 1) begin
            w[25:21] = 5'($urandom_range(0, 3));
            w[20:16] = 5'($urandom_range(0, 3));
        end
        if (pick < 18)      w[31:26] = msx_pkg::OP_ADDI;
        else if (pick < 28) w[31:26] = msx_pkg::OP_ANDI;
        else if (pick < 38) w[31:26] = msx_pkg::OP_ORI;
        else if (pick < 48) w[31:26] = msx_pkg::OP_XORI;
        else if (pick < 66) begin
            w[31:26] = msx_pkg::OP_BEQ;
            if ($urandom_range(0, 1) == 1)
                w[20:16] = w[25:21];
        end
        else if (pick < 74) w[31:26] = msx_pkg::OP_JAL;
        else if (pick < 88) begin
            w[31:26] = msx_pkg::OP_SPECIAL;
            if (pick < 85)
                w[5:0] = msx_pkg::FN_JR;
        end
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] ins,
                             input logic [4:0] lidx, input logic [31:0] lval);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lval, lidx, ins, cmd};
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) @(posedge aclk);
        pending_results.insert(pending_results.size(),
                               predict_result(cmd, ins, lidx, lval));
        items_sent++;
    endtask

    task automatic exec_item(input logic [31:0] ins);
        send_item(msx_pkg::CMD_EXEC, ins, 5'd0, 32'h0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        src_max_gap  = 3;
        sink_max_gap = 3;
        send_item(msx_pkg::CMD_LOAD_REG, 32'h0, 5'd0, 32'hFFFF_FFFF);
        send_item(msx_pkg::CMD_LOAD_REG, 32'h0, 5'd31, 32'h8000_0000);
        send_item(msx_pkg::CMD_LOAD_REG, 32'h0, 5'd1, 32'h7FFF_FFFF);
        exec_item(i_word(msx_pkg::OP_ADDI, 5'd2, 5'd0, 16'h0001));   // wraps to zero
        exec_item(i_word(msx_pkg::OP_ADDI, 5'd3, 5'd1, 16'h8000));   // negative immediate
        exec_item(i_word(msx_pkg::OP_ADDI, 5'd1, 5'd1, 16'h7FFF));
        exec_item(i_word(msx_pkg::OP_ADDI, 5'd1, 5'd1, 16'h0001));   // depends on previous
        exec_item(i_word(msx_pkg::OP_ANDI, 5'd4, 5'd0, 16'hFFFF));
        exec_item(i_word(msx_pkg::OP_ORI,  5'd5, 5'd2, 16'hFFFF));
        exec_item(i_word(msx_pkg::OP_XORI, 5'd0, 5'd0, 16'hFFFF));   // register zero is writable
        send_item(msx_pkg::CMD_LOAD_PC, 32'h0, 5'd0, 32'hFFFF_FFFF);
        exec_item(i_word(msx_pkg::OP_BEQ, 5'd2, 5'd2, 16'h8000));    // taken, backward
        exec_item(i_word(msx_pkg::OP_BEQ, 5'd0, 5'd31, 16'h7FFF));   // not taken
        exec_item({msx_pkg::OP_JAL, 26'h3FF_FFFF});
        // jr with junk bits
        exec_item({msx_pkg::OP_SPECIAL, 5'd31, 5'h1F, 10'h3FF, msx_pkg::FN_JR});
        exec_item({msx_pkg::OP_SPECIAL, 5'd0, 15'h0, msx_pkg::FN_JR});
        exec_item({msx_pkg::OP_SPECIAL, 5'd1, 5'd2, 10'h0, 6'h3F});
        exec_item({msx_pkg::OP_SPECIAL, 26'h0});
        exec_item({6'h3F, 26'h3FF_FFFF});
        exec_item({6'h01, 26'h0});
        send_item(CMD_RESERVED, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
        send_item(msx_pkg::CMD_LOAD_PC, 32'h0, 5'd0, 32'h0);
        exec_item({msx_pkg::OP_JAL, 26'h0});
        send_item(msx_pkg::CMD_LOAD_REG, 32'h0, 5'd31, 32'h0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count, input int src_gap,
                                       input int sink_gap);
        int pick;
        logic [1:0]  cmd;
        logic [4:0]  lidx;
        logic [31:0] lval;
        src_max_gap  = src_gap;
        sink_max_gap = sink_gap;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            lval = $urandom();
            if ($urandom_range(0, 9) == 0)
                lval = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            lidx = 5'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 31));
            if (pick < 72)      cmd = msx_pkg::CMD_EXEC;
            else if (pick < 86) cmd = msx_pkg::CMD_LOAD_REG;
            else if (pick < 95) cmd = msx_pkg::CMD_LOAD_PC;
            else                cmd = CMD_RESERVED;
            send_item(cmd, random_instruction(), lidx, lval);
        end
        drain_results();
    endtask

    // receiver sits still while the sender streams, so the input must stall
    task automatic test_backpressure();
        src_max_gap   = 0;
        sink_max_gap  = 0;
        stall_request = 60;
        repeat (30)
            send_item(msx_pkg::CMD_EXEC, random_instruction(),
                      5'($urandom_range(0, 31)), $urandom());
        drain_results();
    endtask

    initial begin : result_checker
        int n;
        msx_pkg::exec_result_t want;
        logic [31:0] got_pc;
        logic        got_wr;
        logic [4:0]  got_idx;
        logic [31:0] got_val;
        logic        got_unsup;
        forever begin
            if (stall_request > 0) begin
                n = stall_request;
                stall_request = 0;
            end else begin
                n = $urandom_range(0, sink_max_gap);
            end
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (m_axis_tvalid !== 1'b1) @(posedge aclk);
            {got_unsup, got_val, got_idx, got_wr, got_pc} = m_axis_tdata[msx_pkg::OUT_W-1:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected transaction on m_axis, tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", want.next_pc, got_pc);
                check_field("reg_written", {31'b0, want.reg_written}, {31'b0, got_wr});
                check_field("dest_index", {27'b0, want.dest_index}, {27'b0, got_idx});
                check_field("dest_value", want.dest_value, got_val);
                check_field("unsupported", {31'b0, want.unsupported}, {31'b0, got_unsup});
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        foreach (gold_regs[i])
            gold_regs[i] = '0;
        gold_pc = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_traffic(330, 10, 10);
        test_random_traffic(330, 0, 0);
        test_random_traffic(330, 10, 0);
        test_backpressure();
        test_random_traffic(330, 0, 10);

        drain_results();
        repeat (8) @(posedge aclk);
        $display("%0d transactions sent, %0d results checked", items_sent, results_seen);
        $display("%0d taken branches, %0d unsupported words, incl. a 60-cycle result stall",
                 branches_taken, unsupported_seen);
        if (error_count == 0) begin
            $display("mips_subset_execute_unit verification clean");
        end else begin
            $display("mips_subset_execute_unit verification failed");
        end
        $finish;
    end

endmodule
